// ===== src/trmx_pkg.sv =====
// Shared types and constants for the toy register machine execute block.
// Used by trmx_regfile, trmx_alu and toy_register_machine_execute_top.
// No dependencies.
package trmx_pkg;

    // Machine geometry
    localparam int unsigned NUM_REGS      = 7;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned IDX_W         = 3;
    localparam int unsigned TARGET_W      = 10;
    localparam int unsigned PROGRAM_DEPTH = 1024;

    // Register indices; index seven names no register
    localparam logic [IDX_W-1:0] REG_AH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_AL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_BH   = 3'd2;
    localparam logic [IDX_W-1:0] REG_BL   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DH   = 3'd4;
    localparam logic [IDX_W-1:0] REG_DL   = 3'd5;
    localparam logic [IDX_W-1:0] REG_CX   = 3'd6;
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    // int21 service codes held in ah
    localparam logic [WORD_W-1:0] SVC_READ_CHAR  = 32'd1;
    localparam logic [WORD_W-1:0] SVC_PRINT_CHAR = 32'd2;
    localparam logic [WORD_W-1:0] SVC_PRINT_DEC  = 32'd3;

    typedef enum logic [4:0] {
        OP_MOV   = 5'd0,
        OP_ADD   = 5'd1,
        OP_SUB   = 5'd2,
        OP_ANL   = 5'd3,
        OP_ORL   = 5'd4,
        OP_INC   = 5'd5,
        OP_DEC   = 5'd6,
        OP_XCH   = 5'd7,
        OP_CLR   = 5'd8,
        OP_JMP   = 5'd9,
        OP_JG    = 5'd10,
        OP_JL    = 5'd11,
        OP_JE    = 5'd12,
        OP_JNE   = 5'd13,
        OP_JZ    = 5'd14,
        OP_JNZ   = 5'd15,
        OP_LOOP  = 5'd16,
        OP_INT21 = 5'd17,
        OP_INT20 = 5'd18
    } t_opcode;

    typedef enum logic [1:0] {
        PRINT_NONE = 2'd0,
        PRINT_CHAR = 2'd1,
        PRINT_DEC  = 2'd2
    } t_print_kind;

    typedef logic [NUM_REGS-1:0][WORD_W-1:0] t_regs;

    // One decoded instruction
    typedef struct packed {
        logic [4:0]          opcode;
        logic [IDX_W-1:0]    dest_index;
        logic [IDX_W-1:0]    source_index;
        logic                source_is_immediate;
        logic [7:0]          immediate_value;
        logic [TARGET_W-1:0] branch_target;
        logic [7:0]          console_char;
    } t_item;

    // One result
    typedef struct packed {
        logic                branch_taken;
        logic [TARGET_W-1:0] next_index;
        logic [1:0]          print_kind;
        logic [WORD_W-1:0]   print_value;
        logic                halt;
    } t_result;

    // Register file write port
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] data;
    } t_wr_port;

endpackage

// ===== src/trmx_regfile.sv =====
// Seven 32-bit architectural registers with two write ports.
// Depends on trmx_pkg.
module trmx_regfile (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  trmx_pkg::t_wr_port i_wr_a,
    input  trmx_pkg::t_wr_port i_wr_b,
    output trmx_pkg::t_regs    o_regs
);
    import trmx_pkg::*;

    t_regs r_regs;

    // Port b wins when both ports hit the same register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (i_wr_b.en && i_wr_b.idx == IDX_W'(i)) begin
                    r_regs[i] <= i_wr_b.data;
                end else if (i_wr_a.en && i_wr_a.idx == IDX_W'(i)) begin
                    r_regs[i] <= i_wr_a.data;
                end
            end
        end
    end

    assign o_regs = r_regs;

endmodule

// ===== src/trmx_alu.sv =====
// Single-pass execute logic: operand select, ALU, branch and console decode.
// Depends on trmx_pkg.
module trmx_alu (
    input  trmx_pkg::t_item    i_item,
    input  trmx_pkg::t_regs    i_regs,
    output trmx_pkg::t_result  o_result,
    output trmx_pkg::t_wr_port o_wr_a,
    output trmx_pkg::t_wr_port o_wr_b
);
    import trmx_pkg::*;

    logic [WORD_W-1:0]   a_val;
    logic [WORD_W-1:0]   s_val;
    logic [WORD_W-1:0]   b_val;
    logic [WORD_W-1:0]   cx_dec;
    logic [16:0]         target_ext;
    logic [TARGET_W-1:0] target_clamped;
    logic                take;

    // Operand read; the unused index reads as all ones
    always_comb begin
        a_val = (i_item.dest_index == REG_NONE) ? '1 : i_regs[i_item.dest_index];
        s_val = (i_item.source_index == REG_NONE) ? '1 : i_regs[i_item.source_index];
        b_val = i_item.source_is_immediate ? WORD_W'(i_item.immediate_value) : s_val;
    end

    assign cx_dec = i_regs[REG_CX] - WORD_W'(1);

    // Branch target saturates at the end of program memory
    always_comb begin
        target_ext = 17'(i_item.branch_target);
        if (target_ext >= 17'(PROGRAM_DEPTH)) begin
            target_clamped = TARGET_W'(PROGRAM_DEPTH - 1);
        end else begin
            target_clamped = i_item.branch_target;
        end
    end

    // Main decode
    always_comb begin
        o_wr_a          = '0;
        o_wr_b          = '0;
        o_wr_a.idx      = i_item.dest_index;
        take            = 1'b0;
        o_result        = '0;
        unique case (i_item.opcode)
            OP_MOV: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.data = b_val;
            end
            OP_ADD: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.data = a_val + b_val;
            end
            OP_SUB: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.data = a_val - b_val;
            end
            OP_ANL: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.data = WORD_W'((a_val != '0) && (b_val != '0));
            end
            OP_ORL: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.data = WORD_W'((a_val != '0) || (b_val != '0));
            end
            OP_INC: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.data = a_val + WORD_W'(1);
            end
            OP_DEC: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.data = a_val - WORD_W'(1);
            end
            OP_XCH: begin
                // dest gets source, source gets dest; same index leaves it as is
                o_wr_a.en   = 1'b1;
                o_wr_a.data = s_val;
                o_wr_b.en   = 1'b1;
                o_wr_b.idx  = i_item.source_index;
                o_wr_b.data = a_val;
            end
            OP_CLR: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.data = '0;
            end
            OP_JMP:  take = 1'b1;
            OP_JG:   take = $signed(i_regs[REG_BH]) > $signed(i_regs[REG_DH]);
            OP_JL:   take = $signed(i_regs[REG_BH]) < $signed(i_regs[REG_DH]);
            OP_JE:   take = i_regs[REG_BH] == i_regs[REG_DH];
            OP_JNE:  take = i_regs[REG_BH] != i_regs[REG_DH];
            OP_JZ:   take = i_regs[REG_BH] == '0;
            OP_JNZ:  take = i_regs[REG_BH] != '0;
            OP_LOOP: begin
                o_wr_a.en   = 1'b1;
                o_wr_a.idx  = REG_CX;
                o_wr_a.data = cx_dec;
                take        = !cx_dec[WORD_W-1] && (cx_dec != '0);
            end
            OP_INT21: begin
                priority if (i_regs[REG_AH] == SVC_READ_CHAR) begin
                    o_wr_a.en   = 1'b1;
                    o_wr_a.idx  = REG_AL;
                    o_wr_a.data = WORD_W'(i_item.console_char);
                end else if (i_regs[REG_AH] == SVC_PRINT_CHAR) begin
                    o_result.print_kind  = PRINT_CHAR;
                    o_result.print_value = i_regs[REG_DL];
                end else if (i_regs[REG_AH] == SVC_PRINT_DEC) begin
                    o_result.print_kind  = PRINT_DEC;
                    o_result.print_value = i_regs[REG_DL];
                end else begin
                    o_result.print_kind  = PRINT_NONE;
                end
            end
            OP_INT20: o_result.halt = 1'b1;
            default: begin
                // unused opcodes do nothing
            end
        endcase
        o_result.branch_taken = take;
        o_result.next_index   = take ? target_clamped : '0;
    end

endmodule

// ===== src/toy_register_machine_execute_top.sv =====
// Toy register machine execute block, top level.
// Input item register, execute logic with register file, result register.
// Depends on trmx_pkg, trmx_regfile and trmx_alu.
//
// Usage:
//   Input channel: one decoded instruction per transfer on i_in_valid /
//   o_in_stall with fields i_opcode .. i_console_char. Output channel: one
//   result per instruction on o_out_valid / i_out_stall with fields
//   o_branch_taken .. o_halt.
//   An instruction in the input register is executed and its result
//   loaded into the result register, raising o_out_valid. Throughput:
//   one instruction per cycle unless i_out_stall holds a result; the
//   register file is read, updated and written back between the input
//   and result registers in one pass: dependent ones follow back to back.
//   Stall: while i_out_stall holds a result, the input register keeps its
//   instruction and o_in_stall goes high once it is full; the register
//   file only changes when an instruction moves into the result register.
//   Reset (i_rst_n low, synchronous): both pipeline registers are emptied
//   and all seven registers are cleared to zero.
module toy_register_machine_execute_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Instruction channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [4:0]                          i_opcode,
    input  logic [trmx_pkg::IDX_W-1:0]          i_dest_index,
    input  logic [trmx_pkg::IDX_W-1:0]          i_source_index,
    input  logic                                i_source_is_immediate,
    input  logic [7:0]                          i_immediate_value,
    input  logic [trmx_pkg::TARGET_W-1:0]       i_branch_target,
    input  logic [7:0]                          i_console_char,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_branch_taken,
    output logic [trmx_pkg::TARGET_W-1:0]       o_next_index,
    output logic [1:0]                          o_print_kind,
    output logic signed [trmx_pkg::WORD_W-1:0]  o_print_value,
    output logic                                o_halt
);
    import trmx_pkg::*;

    logic     r_in_valid;
    t_item    r_item;
    logic     r_out_valid;
    t_result  r_result;

    logic     exec_go;
    logic     in_load;
    t_regs    regs;
    t_result  exec_result;
    t_wr_port wr_a;
    t_wr_port wr_a_gated;
    t_wr_port wr_b;
    t_wr_port wr_b_gated;

    // Handshake control
    assign exec_go    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign in_load    = !r_in_valid || exec_go;
    assign o_in_stall = r_in_valid && !exec_go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_item.opcode              <= i_opcode;
            r_item.dest_index          <= i_dest_index;
            r_item.source_index        <= i_source_index;
            r_item.source_is_immediate <= i_source_is_immediate;
            r_item.immediate_value     <= i_immediate_value;
            r_item.branch_target       <= i_branch_target;
            r_item.console_char        <= i_console_char;
        end
    end

    // Execute
    trmx_alu u_alu (
        .i_item   (r_item),
        .i_regs   (regs),
        .o_result (exec_result),
        .o_wr_a   (wr_a),
        .o_wr_b   (wr_b)
    );

    // Writes commit only when the instruction moves on
    always_comb begin
        wr_a_gated    = wr_a;
        wr_a_gated.en = wr_a.en && exec_go;
        wr_b_gated    = wr_b;
        wr_b_gated.en = wr_b.en && exec_go;
    end

    trmx_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_a  (wr_a_gated),
        .i_wr_b  (wr_b_gated),
        .o_regs  (regs)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_result <= exec_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_branch_taken = r_result.branch_taken;
    assign o_next_index   = r_result.next_index;
    assign o_print_kind   = r_result.print_kind;
    assign o_print_value  = $signed(r_result.print_value);
    assign o_halt         = r_result.halt;

endmodule
